// ===== hdl/tzsp_pkg.sv =====
// Package for the TZSP decapsulator: parse stages, status codes, tag codes
// and the queue entry that links the parser to the output stage.
// No dependencies.
package tzsp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [7:0] ETH_TYPE_HI    = 8'h08;
   localparam logic [7:0] ETH_TYPE_LO    = 8'h00;
   localparam logic [7:0] HDR_VER_BYTE   = 8'h01;
   localparam logic [7:0] HDR_KIND_BYTE  = 8'h00;
   localparam logic [7:0] TZSP_PROTO_HI  = 8'h00;
   localparam logic [7:0] TZSP_PROTO_LO  = 8'h12;

   localparam logic [7:0] TAG_PADDING   = 8'h00;
   localparam logic [7:0] TAG_END       = 8'h01;
   localparam logic [7:0] TAG_SIGNAL    = 8'h0A;
   localparam logic [7:0] TAG_FCS       = 8'h11;
   localparam logic [7:0] TAG_CHANNEL   = 8'h12;
   localparam logic [7:0] TAG_SENSOR    = 8'h3C;
   localparam logic [7:0] TAG_NONE      = 8'h00;

   typedef enum logic [3:0] {
      STAGE_ETH,
      STAGE_IP,
      STAGE_UDP,
      STAGE_HDR,
      STAGE_TAGTYPE,
      STAGE_TAGLEN,
      STAGE_TAGDATA,
      STAGE_PAYLOAD,
      STAGE_DRAIN
   } stage_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_NOT_IPV4,
      STATUS_BAD_IP_LEN,
      STATUS_BAD_TZSP,
      STATUS_FCS_ERROR,
      STATUS_TRUNCATED
   } status_type;

   typedef struct packed {
      logic              is_status;
      logic [7:0]        payload_byte;
      logic              payload_last;
      status_type        status;
      logic signed [7:0] signal_level;
      logic              signal_seen;
      logic [7:0]        channel_number;
      logic              channel_seen;
      logic [47:0]       sensor_address;
      logic              sensor_seen;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== hdl/tzsp_req_if.sv =====
// Input channel of the TZSP decapsulator: one frame byte per beat.
// No dependencies.
interface tzsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== hdl/tzsp_rsp_if.sv =====
// Result channel of the TZSP decapsulator: payload byte or status with metadata.
// No dependencies.
interface tzsp_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        payload_byte;
   logic              payload_last;
   logic [2:0]        status;
   logic signed [7:0] signal_level;
   logic              signal_seen;
   logic [7:0]        channel_number;
   logic              channel_seen;
   logic [47:0]       sensor_address;
   logic              sensor_seen;

   modport source (output valid, output payload_byte, output payload_last,
                   output status, output signal_level, output signal_seen,
                   output channel_number, output channel_seen,
                   output sensor_address, output sensor_seen, input ready);
   modport sink (input valid, input payload_byte, input payload_last,
                 input status, input signal_level, input signal_seen,
                 input channel_number, input channel_seen,
                 input sensor_address, input sensor_seen, output ready);
endinterface

// ===== hdl/tzsp_front.sv =====
// Parser front end: accepts frame bytes, walks the headers and tags and
// pushes one queue entry per result. Depends on tzsp_pkg and tzsp_req_if.
module tzsp_front (
   input  logic                       clock,
   input  logic                       reset,
   tzsp_req_if.sink                   req,
   input  logic                       csr_write_enable,
   input  logic                       csr_write_data,
   input  tzsp_pkg::queue_status_type q_status,
   output logic                       push,
   output tzsp_pkg::queue_entry_type  push_entry
);
   import tzsp_pkg::*;

   logic              accept_fcs_ff, accept_fcs_in;
   stage_type         stage_ff, stage_in;
   logic [5:0]        count_ff, count_in;
   logic [5:0]        ip_bytes_ff, ip_bytes_in;
   logic [7:0]        tag_ff, tag_in;
   logic [7:0]        left_ff, left_in;
   logic [7:0]        signal_ff, signal_in;
   logic              signal_seen_ff, signal_seen_in;
   logic [7:0]        channel_ff, channel_in;
   logic              channel_seen_ff, channel_seen_in;
   logic [47:0]       sensor_ff, sensor_in;
   logic              sensor_seen_ff, sensor_seen_in;
   status_type        reject_ff, reject_in;

   logic       accept;
   logic [7:0] b;
   logic [5:0] count_next;
   logic       tag_used;
   logic       clear_frame;

   assign req.ready     = !q_status.full;
   assign accept        = req.valid && req.ready;
   assign b             = req.data_byte;
   assign count_next    = count_ff + 6'd1;
   assign accept_fcs_in = csr_write_enable ? csr_write_data : accept_fcs_ff;

   always_comb begin
      tag_used = (((tag_ff == TAG_FCS) || (tag_ff == TAG_SIGNAL) || (tag_ff == TAG_CHANNEL))
                  && (b == 8'd1)) || ((tag_ff == TAG_SENSOR) && (b == 8'd6));
   end

   always_comb begin
      stage_in        = stage_ff;
      count_in        = count_ff;
      ip_bytes_in     = ip_bytes_ff;
      tag_in          = tag_ff;
      left_in         = left_ff;
      signal_in       = signal_ff;
      signal_seen_in  = signal_seen_ff;
      channel_in      = channel_ff;
      channel_seen_in = channel_seen_ff;
      sensor_in       = sensor_ff;
      sensor_seen_in  = sensor_seen_ff;
      reject_in       = reject_ff;
      clear_frame     = 1'b0;
      push            = 1'b0;

      push_entry.is_status      = 1'b0;
      push_entry.payload_byte   = b;
      push_entry.payload_last   = req.frame_end;
      push_entry.status         = STATUS_OK;
      push_entry.signal_level   = signed'(signal_ff);
      push_entry.signal_seen    = signal_seen_ff;
      push_entry.channel_number = channel_ff;
      push_entry.channel_seen   = channel_seen_ff;
      push_entry.sensor_address = sensor_ff;
      push_entry.sensor_seen    = sensor_seen_ff;

      if (accept) begin
         if (stage_ff == STAGE_PAYLOAD) begin
            push        = 1'b1;
            clear_frame = req.frame_end;
         end else if (stage_ff == STAGE_DRAIN) begin
            if (req.frame_end) begin
               push                 = 1'b1;
               push_entry.is_status = 1'b1;
               push_entry.status    = reject_ff;
               clear_frame          = 1'b1;
            end
         end else if (req.frame_end) begin
            push                 = 1'b1;
            push_entry.is_status = 1'b1;
            push_entry.status    = STATUS_TRUNCATED;
            clear_frame          = 1'b1;
         end else begin
            case (stage_ff)
               STAGE_ETH: begin
                  if (((count_ff == 6'd12) && (b != ETH_TYPE_HI)) ||
                      ((count_ff == 6'd13) && (b != ETH_TYPE_LO))) begin
                     reject_in = STATUS_NOT_IPV4;
                     stage_in  = STAGE_DRAIN;
                  end else if (count_next >= 6'd14) begin
                     stage_in = STAGE_IP;
                     count_in = '0;
                  end else begin
                     count_in = count_next;
                  end
               end
               STAGE_IP: begin
                  if (count_ff == 6'd0) begin
                     if (b[3:0] < 4'd5) begin
                        reject_in = STATUS_BAD_IP_LEN;
                        stage_in  = STAGE_DRAIN;
                     end else begin
                        ip_bytes_in = {b[3:0], 2'b00};
                        count_in    = count_next;
                     end
                  end else if (count_next >= ip_bytes_ff) begin
                     stage_in = STAGE_UDP;
                     count_in = '0;
                  end else begin
                     count_in = count_next;
                  end
               end
               STAGE_UDP: begin
                  if (count_next >= 6'd8) begin
                     stage_in = STAGE_HDR;
                     count_in = '0;
                  end else begin
                     count_in = count_next;
                  end
               end
               STAGE_HDR: begin
                  if (((count_ff == 6'd0) && (b != HDR_VER_BYTE)) ||
                      ((count_ff == 6'd1) && (b != HDR_KIND_BYTE)) ||
                      ((count_ff == 6'd2) && (b != TZSP_PROTO_HI)) ||
                      ((count_ff == 6'd3) && (b != TZSP_PROTO_LO))) begin
                     reject_in = STATUS_BAD_TZSP;
                     stage_in  = STAGE_DRAIN;
                  end else if (count_next >= 6'd4) begin
                     stage_in = STAGE_TAGTYPE;
                     count_in = '0;
                  end else begin
                     count_in = count_next;
                  end
               end
               STAGE_TAGTYPE: begin
                  if (b == TAG_END) begin
                     stage_in = STAGE_PAYLOAD;
                  end else if (b != TAG_PADDING) begin
                     tag_in   = b;
                     stage_in = STAGE_TAGLEN;
                  end
               end
               STAGE_TAGLEN: begin
                  if (!tag_used) begin
                     tag_in = TAG_NONE;
                  end
                  left_in  = b;
                  stage_in = (b == 8'd0) ? STAGE_TAGTYPE : STAGE_TAGDATA;
               end
               STAGE_TAGDATA: begin
                  if ((tag_ff == TAG_FCS) && (b != 8'd0) && !accept_fcs_ff) begin
                     reject_in = STATUS_FCS_ERROR;
                     stage_in  = STAGE_DRAIN;
                  end else begin
                     if (tag_ff == TAG_SIGNAL) begin
                        signal_in      = b;
                        signal_seen_in = 1'b1;
                     end else if (tag_ff == TAG_CHANNEL) begin
                        channel_in      = b;
                        channel_seen_in = 1'b1;
                     end else if (tag_ff == TAG_SENSOR) begin
                        sensor_in      = {sensor_ff[39:0], b};
                        sensor_seen_in = 1'b1;
                     end
                     left_in = left_ff - 8'd1;
                     if (left_ff == 8'd1) begin
                        stage_in = STAGE_TAGTYPE;
                     end
                  end
               end
               default: begin
                  reject_in = STATUS_TRUNCATED;
                  stage_in  = STAGE_DRAIN;
               end
            endcase
         end

         if (clear_frame) begin
            stage_in        = STAGE_ETH;
            count_in        = '0;
            ip_bytes_in     = '0;
            tag_in          = TAG_NONE;
            left_in         = '0;
            signal_in       = '0;
            signal_seen_in  = 1'b0;
            channel_in      = '0;
            channel_seen_in = 1'b0;
            sensor_in       = '0;
            sensor_seen_in  = 1'b0;
            reject_in       = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_fcs_ff   <= 1'b0;
         stage_ff        <= STAGE_ETH;
         count_ff        <= '0;
         ip_bytes_ff     <= '0;
         tag_ff          <= TAG_NONE;
         left_ff         <= '0;
         signal_ff       <= '0;
         signal_seen_ff  <= 1'b0;
         channel_ff      <= '0;
         channel_seen_ff <= 1'b0;
         sensor_ff       <= '0;
         sensor_seen_ff  <= 1'b0;
         reject_ff       <= STATUS_OK;
      end else begin
         accept_fcs_ff   <= accept_fcs_in;
         stage_ff        <= stage_in;
         count_ff        <= count_in;
         ip_bytes_ff     <= ip_bytes_in;
         tag_ff          <= tag_in;
         left_ff         <= left_in;
         signal_ff       <= signal_in;
         signal_seen_ff  <= signal_seen_in;
         channel_ff      <= channel_in;
         channel_seen_ff <= channel_seen_in;
         sensor_ff       <= sensor_in;
         sensor_seen_ff  <= sensor_seen_in;
         reject_ff       <= reject_in;
      end
   end

endmodule

// ===== hdl/tzsp_queue.sv =====
// Short register FIFO between the parser and the output stage.
// Depends on tzsp_pkg.
module tzsp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tzsp_pkg::queue_entry_type   push_entry,
   input  logic                        pop,
   output tzsp_pkg::queue_entry_type   pop_entry,
   output tzsp_pkg::queue_status_type  q_status
);
   import tzsp_pkg::*;

   queue_entry_type          slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign q_status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.not_empty = (count_ff != '0);
   assign do_push            = push && !q_status.full;
   assign do_pop             = pop && q_status.not_empty;
   assign pop_entry          = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_PTR_W'((wr_ptr_ff + 1'b1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QUEUE_PTR_W'((rd_ptr_ff + 1'b1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/tzsp_back.sv =====
// Output stage: takes queue entries, forms the result beat and holds it in
// the output register until taken. Depends on tzsp_pkg and tzsp_rsp_if.
module tzsp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tzsp_pkg::queue_status_type q_status,
   input  tzsp_pkg::queue_entry_type  pop_entry,
   output logic                       pop,
   tzsp_rsp_if.source                 rsp
);
   import tzsp_pkg::*;

   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [2:0]        status_ff, status_in;
   logic signed [7:0] signal_ff, signal_in;
   logic              signal_seen_ff, signal_seen_in;
   logic [7:0]        channel_ff, channel_in;
   logic              channel_seen_ff, channel_seen_in;
   logic [47:0]       sensor_ff, sensor_in;
   logic              sensor_seen_ff, sensor_seen_in;

   assign pop      = q_status.not_empty && (!valid_ff || rsp.ready);
   assign valid_in = pop || (valid_ff && !rsp.ready);

   always_comb begin
      byte_in         = byte_ff;
      last_in         = last_ff;
      status_in       = status_ff;
      signal_in       = signal_ff;
      signal_seen_in  = signal_seen_ff;
      channel_in      = channel_ff;
      channel_seen_in = channel_seen_ff;
      sensor_in       = sensor_ff;
      sensor_seen_in  = sensor_seen_ff;
      if (pop) begin
         if (pop_entry.is_status) begin
            byte_in         = '0;
            last_in         = 1'b1;
            status_in       = 3'(pop_entry.status);
            signal_in       = '0;
            signal_seen_in  = 1'b0;
            channel_in      = '0;
            channel_seen_in = 1'b0;
            sensor_in       = '0;
            sensor_seen_in  = 1'b0;
         end else begin
            byte_in         = pop_entry.payload_byte;
            last_in         = pop_entry.payload_last;
            status_in       = 3'(STATUS_OK);
            signal_in       = pop_entry.signal_level;
            signal_seen_in  = pop_entry.signal_seen;
            channel_in      = pop_entry.channel_number;
            channel_seen_in = pop_entry.channel_seen;
            sensor_in       = pop_entry.sensor_address;
            sensor_seen_in  = pop_entry.sensor_seen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff         <= byte_in;
      last_ff         <= last_in;
      status_ff       <= status_in;
      signal_ff       <= signal_in;
      signal_seen_ff  <= signal_seen_in;
      channel_ff      <= channel_in;
      channel_seen_ff <= channel_seen_in;
      sensor_ff       <= sensor_in;
      sensor_seen_ff  <= sensor_seen_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.payload_byte   = byte_ff;
   assign rsp.payload_last   = last_ff;
   assign rsp.status         = status_ff;
   assign rsp.signal_level   = signal_ff;
   assign rsp.signal_seen    = signal_seen_ff;
   assign rsp.channel_number = channel_ff;
   assign rsp.channel_seen   = channel_seen_ff;
   assign rsp.sensor_address = sensor_ff;
   assign rsp.sensor_seen    = sensor_seen_ff;

endmodule

// ===== hdl/tzsp_frame_decapsulator_unit.sv =====
// Top level of the TZSP-over-UDP decapsulator: parser, queue, output stage.
// Depends on tzsp_pkg, tzsp_req_if, tzsp_rsp_if, tzsp_front, tzsp_queue, tzsp_back.
//
//   channel   direction  beat contents
//   req_chan  in         data_byte, frame_end
//   rsp_chan  out        payload_byte, payload_last, status, tag metadata
//   csr_*     in         accept_fcs_error (write only)
//
// One byte is accepted per cycle while the queue is not full; each state update
// is a single parser step. A result passes from its byte through the four-entry
// queue and the output register. Reset is synchronous.
// A stalled result holds in the output register while the queue fills; input
// ready drops only when the queue is full.
module tzsp_frame_decapsulator_unit (
   input  logic        clock,
   input  logic        reset,
   tzsp_req_if.sink    req_chan,
   tzsp_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import tzsp_pkg::*;

   logic             push, pop;
   queue_entry_type  push_entry, pop_entry;
   queue_status_type q_status;

   tzsp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   tzsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   tzsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != 3'(STATUS_OK))) |->
      (rsp_chan.payload_last && (rsp_chan.payload_byte == 8'd0) &&
       !rsp_chan.signal_seen && !rsp_chan.channel_seen && !rsp_chan.sensor_seen))
      else $error("status result not a clean last beat");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into a full queue");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif

endmodule
